>>> sv/best_fit_heap_allocator_assert.svh
// Assertion macros for the best-fit heap allocator.
// Depends on clk and rst_n being visible where a macro is used.
`ifndef BEST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`define BEST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define BFHA_ASSERT_IMP(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("bfha assertion failed");
`define BFHA_ASSERT_NXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("bfha assertion failed");
`else
`define BFHA_ASSERT_IMP(lbl, pre, post)
`define BFHA_ASSERT_NXT(lbl, pre, post)
`endif
`endif

>>> sv/bfha_pkg.sv
// Shared types and constants of the best-fit heap allocator.
// No dependencies.
package bfha_pkg;

    localparam int REQ_W   = 13;
    localparam int ADDR_W  = 12;
    localparam int BYTES_W = 13;
    localparam int PROD_W  = 2 * REQ_W;
    localparam int NEED_W  = PROD_W + 1;
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = 1;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } bfha_op_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NO_HEAP    = 2'd1,
        ST_TABLE_FULL = 2'd2,
        ST_NOT_FOUND  = 2'd3
    } bfha_status_t;

    typedef struct packed {
        bfha_op_t              op;
        logic [NEED_W-1:0]     need;
        logic [ADDR_W-1:0]     faddr;
    } bfha_req_t;

    typedef struct packed {
        logic      push;
        bfha_req_t data;
    } bfha_push_t;

    typedef struct packed {
        logic      vld;
        bfha_req_t data;
    } bfha_head_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_SCAN,
        B_DECIDE,
        B_SHIFT,
        B_WR_REM,
        B_WR_BEST,
        B_APPEND,
        B_FLUSH,
        B_DONE
    } bfha_state_t;

endpackage

>>> sv/bfha_front.sv
// Request front end: takes command words, forms the byte need, pushes to the queue.
// Depends on bfha_pkg.
module bfha_front #(
    parameter int HEADER_BYTES = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          op,
    input  logic [bfha_pkg::REQ_W-1:0]    req_count,
    input  logic [bfha_pkg::REQ_W-1:0]    req_size,
    input  logic [bfha_pkg::ADDR_W-1:0]   free_address,
    input  logic                          q_full,
    output logic                          busy,
    output bfha_pkg::bfha_push_t          q_push
);

    logic                            stg_vld_reg, stg_vld_next;
    bfha_pkg::bfha_op_t              stg_op_reg;
    logic [bfha_pkg::PROD_W-1:0]     stg_prod_reg;
    logic [bfha_pkg::ADDR_W-1:0]     stg_faddr_reg;
    logic [bfha_pkg::PROD_W-1:0]     prod;
    logic                            accept;
    logic                            push;

    assign prod   = req_count * req_size;
    assign push   = stg_vld_reg && !q_full;
    assign busy   = stg_vld_reg && q_full;
    assign accept = start && !busy;

    always_comb
    begin
        stg_vld_next = stg_vld_reg;
        if (accept)
        begin
            stg_vld_next = 1'b1;
        end
        else if (push)
        begin
            stg_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_vld_reg <= 1'b0;
        end
        else
        begin
            stg_vld_reg <= stg_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stg_op_reg    <= bfha_pkg::bfha_op_t'(op);
            stg_prod_reg  <= prod;
            stg_faddr_reg <= free_address;
        end
    end

    always_comb
    begin
        q_push.push       = push;
        q_push.data.op    = stg_op_reg;
        q_push.data.need  = bfha_pkg::NEED_W'(stg_prod_reg)
                          + bfha_pkg::NEED_W'(HEADER_BYTES);
        q_push.data.faddr = stg_faddr_reg;
    end

endmodule

>>> sv/bfha_queue.sv
// Two-word request queue between front end and table engine.
// Depends on bfha_pkg.
module bfha_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  bfha_pkg::bfha_push_t  q_push,
    input  logic                  pop,
    output logic                  full,
    output bfha_pkg::bfha_head_t  head
);

    bfha_pkg::bfha_req_t                 entry_reg [bfha_pkg::QDEPTH];
    logic [bfha_pkg::QPTR_W-1:0]         wr_ptr_reg, wr_ptr_next;
    logic [bfha_pkg::QPTR_W-1:0]         rd_ptr_reg, rd_ptr_next;
    logic [bfha_pkg::QPTR_W:0]           fill_reg, fill_next;

    assign full      = (fill_reg == (bfha_pkg::QPTR_W+1)'(bfha_pkg::QDEPTH));
    assign head.vld  = (fill_reg != '0);
    assign head.data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (q_push.push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (q_push.push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (!q_push.push && pop)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_push.push)
        begin
            entry_reg[wr_ptr_reg] <= q_push.data;
        end
    end

endmodule

>>> sv/bfha_back.sv
// Segment table engine: best-fit search, split, append, free with merge.
// Depends on bfha_pkg and best_fit_heap_allocator_assert.svh.
`include "best_fit_heap_allocator_assert.svh"
module bfha_back #(
    parameter int HEAP_BYTES   = 4096,
    parameter int HEADER_BYTES = 8,
    parameter int MAX_SEGMENTS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bfha_pkg::bfha_head_t          head,
    output logic                          pop,
    output logic                          done,
    output logic [bfha_pkg::ADDR_W-1:0]   user_address,
    output logic [1:0]                    status,
    output logic [bfha_pkg::BYTES_W-1:0]  bytes_in_use
);

    localparam int SW   = $clog2(HEAP_BYTES + 1);
    localparam int CW   = $clog2(MAX_SEGMENTS + 1);
    localparam int IW   = $clog2(MAX_SEGMENTS);
    localparam int CMPW = SW + 5;
    localparam int NW   = bfha_pkg::NEED_W;

    bfha_pkg::bfha_state_t  state_reg, state_next;

    bfha_pkg::bfha_op_t     op_reg, op_next;
    logic [NW-1:0]          need_reg, need_next;
    logic [bfha_pkg::ADDR_W-1:0] faddr_reg, faddr_next;

    logic [CW-1:0]          seg_count_reg, seg_count_next;
    logic [SW-1:0]          heap_top_reg, heap_top_next;
    logic [SW-1:0]          used_total_reg, used_total_next;
    logic [MAX_SEGMENTS-1:0] used_reg, used_next;

    logic [CW-1:0]          rd_idx_reg, rd_idx_next;
    logic                   ev_vld_reg, ev_vld_next;
    logic [IW-1:0]          ev_idx_reg, ev_idx_next;
    logic [SW-1:0]          start_acc_reg, start_acc_next;

    logic                   found_reg, found_next;
    logic [IW-1:0]          best_idx_reg, best_idx_next;
    logic [SW-1:0]          best_size_reg, best_size_next;
    logic [SW-1:0]          best_start_reg, best_start_next;

    logic                   pend_vld_reg, pend_vld_next;
    logic                   pend_used_reg, pend_used_next;
    logic [SW-1:0]          pend_size_reg, pend_size_next;
    logic [CW-1:0]          wr_idx_reg, wr_idx_next;

    logic [CW-1:0]          sh_src_reg, sh_src_next;
    logic                   sh_wvld_reg, sh_wvld_next;
    logic [IW-1:0]          sh_dst_reg, sh_dst_next;

    logic [bfha_pkg::ADDR_W-1:0] res_addr_reg, res_addr_next;
    bfha_pkg::bfha_status_t res_status_reg, res_status_next;

    logic [SW-1:0]          mem [MAX_SEGMENTS];
    logic [SW-1:0]          rd_data_reg;
    logic [IW-1:0]          ra;
    logic                   we;
    logic [IW-1:0]          wa;
    logic [SW-1:0]          wd;

    logic                   scan_issue;
    logic                   scan_end;
    logic                   sh_issue;
    logic                   sh_end;
    logic                   ev_used;
    logic                   ev_match;
    logic                   ev_used_eff;
    logic                   ev_fits;
    logic                   ev_merge;
    logic                   split;
    logic                   no_room;
    logic [IW-1:0]          best_nxt_idx;
    logic [bfha_pkg::ADDR_W-1:0] best_uaddr;

    assign scan_issue  = (rd_idx_reg < seg_count_reg);
    assign scan_end    = !scan_issue && !ev_vld_reg;
    assign sh_issue    = (sh_src_reg > CW'(best_idx_reg));
    assign sh_end      = !sh_issue && !sh_wvld_reg;
    assign ev_used     = used_reg[ev_idx_reg];
    assign ev_match    = ((CMPW'(start_acc_reg) + CMPW'(HEADER_BYTES)) == CMPW'(faddr_reg));
    assign ev_used_eff = ev_used && !ev_match;
    assign ev_fits     = !ev_used && (NW'(rd_data_reg) >= need_reg)
                      && (!found_reg || (rd_data_reg < best_size_reg));
    assign ev_merge    = pend_vld_reg && !pend_used_reg && !ev_used_eff;
    assign split       = (NW'(best_size_reg) > need_reg) && (seg_count_reg < CW'(MAX_SEGMENTS));
    assign no_room     = need_reg > (NW'(HEAP_BYTES) - NW'(heap_top_reg));
    assign best_nxt_idx = best_idx_reg + 1'b1;
    assign best_uaddr  = bfha_pkg::ADDR_W'(CMPW'(best_start_reg) + CMPW'(HEADER_BYTES));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bfha_pkg::B_IDLE:
            begin
                if (head.vld)
                begin
                    state_next = bfha_pkg::B_SCAN;
                end
            end
            bfha_pkg::B_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = (op_reg == bfha_pkg::OP_ALLOC) ? bfha_pkg::B_DECIDE
                                                                : bfha_pkg::B_FLUSH;
                end
            end
            bfha_pkg::B_DECIDE:
            begin
                if (found_reg)
                begin
                    state_next = split ? bfha_pkg::B_SHIFT : bfha_pkg::B_DONE;
                end
                else if (no_room || (seg_count_reg >= CW'(MAX_SEGMENTS)))
                begin
                    state_next = bfha_pkg::B_DONE;
                end
                else
                begin
                    state_next = bfha_pkg::B_APPEND;
                end
            end
            bfha_pkg::B_SHIFT:
            begin
                if (sh_end)
                begin
                    state_next = bfha_pkg::B_WR_REM;
                end
            end
            bfha_pkg::B_WR_REM:  state_next = bfha_pkg::B_WR_BEST;
            bfha_pkg::B_WR_BEST: state_next = bfha_pkg::B_DONE;
            bfha_pkg::B_APPEND:  state_next = bfha_pkg::B_DONE;
            bfha_pkg::B_FLUSH:   state_next = bfha_pkg::B_DONE;
            bfha_pkg::B_DONE:    state_next = bfha_pkg::B_IDLE;
            default:             state_next = bfha_pkg::B_IDLE;
        endcase
    end

    // outputs and memory port control
    always_comb
    begin
        pop  = 1'b0;
        done = 1'b0;
        ra   = '0;
        we   = 1'b0;
        wa   = '0;
        wd   = '0;
        unique case (state_reg)
            bfha_pkg::B_IDLE:
            begin
                pop = head.vld;
            end
            bfha_pkg::B_SCAN:
            begin
                ra = rd_idx_reg[IW-1:0];
                if ((op_reg == bfha_pkg::OP_FREE) && ev_vld_reg && !ev_merge && pend_vld_reg)
                begin
                    we = 1'b1;
                    wa = wr_idx_reg[IW-1:0];
                    wd = pend_size_reg;
                end
            end
            bfha_pkg::B_SHIFT:
            begin
                ra = sh_src_reg[IW-1:0];
                we = sh_wvld_reg;
                wa = sh_dst_reg;
                wd = rd_data_reg;
            end
            bfha_pkg::B_WR_REM:
            begin
                we = 1'b1;
                wa = best_nxt_idx;
                wd = best_size_reg - need_reg[SW-1:0];
            end
            bfha_pkg::B_WR_BEST:
            begin
                we = 1'b1;
                wa = best_idx_reg;
                wd = need_reg[SW-1:0];
            end
            bfha_pkg::B_APPEND:
            begin
                we = 1'b1;
                wa = seg_count_reg[IW-1:0];
                wd = need_reg[SW-1:0];
            end
            bfha_pkg::B_FLUSH:
            begin
                we = pend_vld_reg;
                wa = wr_idx_reg[IW-1:0];
                wd = pend_size_reg;
            end
            bfha_pkg::B_DONE:
            begin
                done = 1'b1;
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        op_next         = op_reg;
        need_next       = need_reg;
        faddr_next      = faddr_reg;
        seg_count_next  = seg_count_reg;
        heap_top_next   = heap_top_reg;
        used_total_next = used_total_reg;
        used_next       = used_reg;
        rd_idx_next     = rd_idx_reg;
        ev_vld_next     = 1'b0;
        ev_idx_next     = ev_idx_reg;
        start_acc_next  = start_acc_reg;
        found_next      = found_reg;
        best_idx_next   = best_idx_reg;
        best_size_next  = best_size_reg;
        best_start_next = best_start_reg;
        pend_vld_next   = pend_vld_reg;
        pend_used_next  = pend_used_reg;
        pend_size_next  = pend_size_reg;
        wr_idx_next     = wr_idx_reg;
        sh_src_next     = sh_src_reg;
        sh_wvld_next    = 1'b0;
        sh_dst_next     = sh_dst_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;
        case (state_reg)
            bfha_pkg::B_IDLE:
            begin
                if (head.vld)
                begin
                    op_next         = head.data.op;
                    need_next       = head.data.need;
                    faddr_next      = head.data.faddr;
                    rd_idx_next     = '0;
                    start_acc_next  = '0;
                    found_next      = 1'b0;
                    pend_vld_next   = 1'b0;
                    wr_idx_next     = '0;
                    res_addr_next   = '0;
                    res_status_next = bfha_pkg::ST_OK;
                end
            end
            bfha_pkg::B_SCAN:
            begin
                if (scan_issue)
                begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                    ev_vld_next = 1'b1;
                    ev_idx_next = rd_idx_reg[IW-1:0];
                end
                if (ev_vld_reg)
                begin
                    start_acc_next = start_acc_reg + rd_data_reg;
                    if (op_reg == bfha_pkg::OP_ALLOC)
                    begin
                        if (ev_fits)
                        begin
                            found_next      = 1'b1;
                            best_idx_next   = ev_idx_reg;
                            best_size_next  = rd_data_reg;
                            best_start_next = start_acc_reg;
                        end
                    end
                    else
                    begin
                        if (ev_match)
                        begin
                            found_next = 1'b1;
                            if (ev_used)
                            begin
                                used_total_next = used_total_reg - rd_data_reg;
                            end
                        end
                        // stream compaction: adjacent free segments fold together
                        if (ev_merge)
                        begin
                            pend_size_next = pend_size_reg + rd_data_reg;
                        end
                        else
                        begin
                            if (pend_vld_reg)
                            begin
                                used_next[wr_idx_reg[IW-1:0]] = pend_used_reg;
                                wr_idx_next = wr_idx_reg + 1'b1;
                            end
                            pend_vld_next  = 1'b1;
                            pend_used_next = ev_used_eff;
                            pend_size_next = rd_data_reg;
                        end
                    end
                end
            end
            bfha_pkg::B_DECIDE:
            begin
                if (found_reg)
                begin
                    res_addr_next = best_uaddr;
                    if (split)
                    begin
                        sh_src_next = seg_count_reg - 1'b1;
                    end
                    else
                    begin
                        used_next[best_idx_reg] = 1'b1;
                        used_total_next = used_total_reg + best_size_reg;
                    end
                end
                else if (no_room)
                begin
                    res_status_next = bfha_pkg::ST_NO_HEAP;
                end
                else if (seg_count_reg >= CW'(MAX_SEGMENTS))
                begin
                    res_status_next = bfha_pkg::ST_TABLE_FULL;
                end
            end
            bfha_pkg::B_SHIFT:
            begin
                if (sh_issue)
                begin
                    sh_src_next  = sh_src_reg - 1'b1;
                    sh_wvld_next = 1'b1;
                    sh_dst_next  = sh_src_reg[IW-1:0] + 1'b1;
                end
            end
            bfha_pkg::B_WR_REM:
            begin
                for (int j = 1; j < MAX_SEGMENTS; j++)
                begin
                    if (IW'(j) > best_nxt_idx)
                    begin
                        used_next[j] = used_reg[j-1];
                    end
                end
                used_next[best_nxt_idx] = 1'b0;
                used_next[best_idx_reg] = 1'b1;
                seg_count_next  = seg_count_reg + 1'b1;
                used_total_next = used_total_reg + need_reg[SW-1:0];
            end
            bfha_pkg::B_APPEND:
            begin
                used_next[seg_count_reg[IW-1:0]] = 1'b1;
                seg_count_next  = seg_count_reg + 1'b1;
                heap_top_next   = heap_top_reg + need_reg[SW-1:0];
                used_total_next = used_total_reg + need_reg[SW-1:0];
                res_addr_next   = bfha_pkg::ADDR_W'(CMPW'(heap_top_reg) + CMPW'(HEADER_BYTES));
            end
            bfha_pkg::B_FLUSH:
            begin
                if (pend_vld_reg)
                begin
                    used_next[wr_idx_reg[IW-1:0]] = pend_used_reg;
                    seg_count_next = wr_idx_reg + 1'b1;
                end
                res_status_next = found_reg ? bfha_pkg::ST_OK : bfha_pkg::ST_NOT_FOUND;
            end
            default:
            begin
                ev_vld_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= bfha_pkg::B_IDLE;
            seg_count_reg  <= '0;
            heap_top_reg   <= '0;
            used_total_reg <= '0;
            used_reg       <= '0;
            ev_vld_reg     <= 1'b0;
            sh_wvld_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            seg_count_reg  <= seg_count_next;
            heap_top_reg   <= heap_top_next;
            used_total_reg <= used_total_next;
            used_reg       <= used_next;
            ev_vld_reg     <= ev_vld_next;
            sh_wvld_reg    <= sh_wvld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        need_reg       <= need_next;
        faddr_reg      <= faddr_next;
        rd_idx_reg     <= rd_idx_next;
        ev_idx_reg     <= ev_idx_next;
        start_acc_reg  <= start_acc_next;
        found_reg      <= found_next;
        best_idx_reg   <= best_idx_next;
        best_size_reg  <= best_size_next;
        best_start_reg <= best_start_next;
        pend_vld_reg   <= pend_vld_next;
        pend_used_reg  <= pend_used_next;
        pend_size_reg  <= pend_size_next;
        wr_idx_reg     <= wr_idx_next;
        sh_src_reg     <= sh_src_next;
        sh_dst_reg     <= sh_dst_next;
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
    end

    // segment size table
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        rd_data_reg <= mem[ra];
    end

    assign user_address = res_addr_reg;
    assign status       = res_status_reg;
    assign bytes_in_use = bfha_pkg::BYTES_W'(used_total_reg);

    `BFHA_ASSERT_IMP(a_count_bound, 1'b1, seg_count_reg <= CW'(MAX_SEGMENTS))
    `BFHA_ASSERT_IMP(a_used_le_top, 1'b1, used_total_reg <= heap_top_reg)
    `BFHA_ASSERT_NXT(a_done_pulse, state_reg == bfha_pkg::B_DONE, state_reg == bfha_pkg::B_IDLE)
    `BFHA_ASSERT_IMP(a_scan_bound, state_reg == bfha_pkg::B_SCAN, rd_idx_reg <= seg_count_reg)

endmodule

>>> sv/best_fit_heap_allocator.sv
// Top level of the best-fit heap allocator.
// Depends on bfha_pkg, bfha_front, bfha_queue and bfha_back.
//
// Command channel: a word is taken at a clock edge with start high and busy low.
// op selects allocate (req_count * req_size + header bytes) or free (free_address).
// Result channel: done is high for one cycle with user_address, status and
// bytes_in_use; the receiver cannot stall, so every result is taken that cycle.
// The front end forms the byte need in one registered stage and parks the word in
// a two-word queue, so commands are taken while the table engine is working.
// Each request walks the segment table through a single-read-port memory.
// After the front stage and the queue, the engine scans the whole segment table,
// then follows one of these paths to the state with done:
//   free: flush; refused allocate, allocate into a free segment: decide
//   allocate appended at the heap top: decide, append
//   allocate with a split: decide, shift, write remainder, write best
// Words pass the engine one at a time.
// busy rises only when the front stage and the queue are both occupied.
// Reset empties the segment table, the queue and all counters; no clearing pass.
module best_fit_heap_allocator #(
    parameter int HEAP_BYTES   = 4096,
    parameter int HEADER_BYTES = 8,
    parameter int MAX_SEGMENTS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          op,
    input  logic [bfha_pkg::REQ_W-1:0]    req_count,
    input  logic [bfha_pkg::REQ_W-1:0]    req_size,
    input  logic [bfha_pkg::ADDR_W-1:0]   free_address,
    output logic                          done,
    output logic [bfha_pkg::ADDR_W-1:0]   user_address,
    output logic [1:0]                    status,
    output logic [bfha_pkg::BYTES_W-1:0]  bytes_in_use
);

    bfha_pkg::bfha_push_t  q_push;
    bfha_pkg::bfha_head_t  q_head;
    logic                  q_full;
    logic                  q_pop;

    bfha_front #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .op           (op),
        .req_count    (req_count),
        .req_size     (req_size),
        .free_address (free_address),
        .q_full       (q_full),
        .busy         (busy),
        .q_push       (q_push)
    );

    bfha_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_push (q_push),
        .pop    (q_pop),
        .full   (q_full),
        .head   (q_head)
    );

    bfha_back #(
        .HEAP_BYTES   (HEAP_BYTES),
        .HEADER_BYTES (HEADER_BYTES),
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (q_head),
        .pop          (q_pop),
        .done         (done),
        .user_address (user_address),
        .status       (status),
        .bytes_in_use (bytes_in_use)
    );

endmodule
